// ===== hdl/dwbm_pkg.sv =====
// shared types, constants and boot image for the delayed write bank mapper
`default_nettype none

package dwbm_pkg;

  localparam int BANK_BYTES_DEF = 2048;

  localparam logic [11:0] ADDR_CFG = 12'hFF8;
  localparam logic [1:0]  BANK_ROM = 2'd3;
  localparam logic [31:0] DUE_GAP  = 32'd5;

  localparam int BOOT_LEN = 294;
  localparam int BOOT_AW  = $clog2(BOOT_LEN);
  localparam logic [7:0] BOOT_FILL = 8'h02;
  localparam logic [7:0] VEC_LO    = 8'h0A;
  localparam logic [7:0] VEC_HI    = 8'hF8;

  localparam logic [7:0] BOOT_CODE [BOOT_LEN] = '{
    8'ha5,8'hfa,8'h85,8'h80,8'h4c,8'h18,8'hf8,8'hff, 8'hff,8'hff,8'h78,8'hd8,8'ha0,8'h00,8'ha2,8'h00,
    8'h94,8'h00,8'he8,8'hd0,8'hfb,8'h4c,8'h50,8'hf8, 8'ha2,8'h00,8'hbd,8'h06,8'hf0,8'had,8'hf8,8'hff,
    8'ha2,8'h00,8'had,8'h00,8'hf0,8'hea,8'hbd,8'h00, 8'hf7,8'hca,8'hd0,8'hf6,8'h4c,8'h50,8'hf8,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff, 8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff, 8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'ha2,8'h03,8'hbc,8'h22,8'hf9,8'h94,8'hfa,8'hca, 8'h10,8'hf8,8'ha0,8'h00,8'ha2,8'h28,8'h94,8'h04,
    8'hca,8'h10,8'hfb,8'ha2,8'h1c,8'h94,8'h81,8'hca, 8'h10,8'hfb,8'ha9,8'hff,8'hc9,8'h00,8'hd0,8'h03,
    8'h4c,8'h13,8'hf9,8'ha9,8'h00,8'h85,8'h1b,8'h85, 8'h1c,8'h85,8'h1d,8'h85,8'h1e,8'h85,8'h1f,8'h85,
    8'h19,8'h85,8'h1a,8'h85,8'h08,8'h85,8'h01,8'ha9, 8'h10,8'h85,8'h21,8'h85,8'h02,8'ha2,8'h07,8'hca,
    8'hca,8'hd0,8'hfd,8'ha9,8'h00,8'h85,8'h20,8'h85, 8'h10,8'h85,8'h11,8'h85,8'h02,8'h85,8'h2a,8'ha9,
    8'h05,8'h85,8'h0a,8'ha9,8'hff,8'h85,8'h0d,8'h85, 8'h0e,8'h85,8'h0f,8'h85,8'h84,8'h85,8'h85,8'ha9,
    8'hf0,8'h85,8'h83,8'ha9,8'h74,8'h85,8'h09,8'ha9, 8'h0c,8'h85,8'h15,8'ha9,8'h1f,8'h85,8'h17,8'h85,
    8'h82,8'ha9,8'h07,8'h85,8'h19,8'ha2,8'h08,8'ha0, 8'h00,8'h85,8'h02,8'h88,8'hd0,8'hfb,8'h85,8'h02,
    8'h85,8'h02,8'ha9,8'h02,8'h85,8'h02,8'h85,8'h00, 8'h85,8'h02,8'h85,8'h02,8'h85,8'h02,8'ha9,8'h00,
    8'h85,8'h00,8'hca,8'h10,8'he4,8'h06,8'h83,8'h66, 8'h84,8'h26,8'h85,8'ha5,8'h83,8'h85,8'h0d,8'ha5,
    8'h84,8'h85,8'h0e,8'ha5,8'h85,8'h85,8'h0f,8'ha6, 8'h82,8'hca,8'h86,8'h82,8'h86,8'h17,8'he0,8'h0a,
    8'hd0,8'hc3,8'ha9,8'h02,8'h85,8'h01,8'ha2,8'h1c, 8'ha0,8'h00,8'h84,8'h19,8'h84,8'h09,8'h94,8'h81,
    8'hca,8'h10,8'hfb,8'ha6,8'h80,8'hdd,8'h00,8'hf0, 8'ha9,8'h9a,8'ha2,8'hff,8'ha0,8'h00,8'h9a,8'h4c,
    8'hfa,8'h00,8'hcd,8'hf8,8'hff,8'h4c
  };

  typedef struct packed {
    logic        command;
    logic [11:0] address;
    logic [31:0] access_count;
  } dwbm_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rom_powered;
    logic       write_enabled;
    logic [1:0] lower_bank;
    logic [1:0] upper_bank;
  } dwbm_out_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic fetch;
  } dwbm_cmd_t;

  function automatic logic [7:0] boot_byte(input logic [11:0] idx);
    logic [7:0] b;
    if (idx < 12'(BOOT_LEN)) begin
      b = BOOT_CODE[idx[BOOT_AW-1:0]];
    end else begin
      b = BOOT_FILL;
    end
    return b;
  endfunction

  function automatic logic [1:0] map_lower(input logic [2:0] m);
    logic [1:0] b;
    case (m)
      3'd0: b = 2'd2;
      3'd1: b = 2'd0;
      3'd2: b = 2'd2;
      3'd3: b = 2'd0;
      3'd4: b = 2'd2;
      3'd5: b = 2'd1;
      3'd6: b = 2'd2;
      3'd7: b = 2'd1;
      default: b = 2'd2;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] map_upper(input logic [2:0] m);
    logic [1:0] b;
    case (m)
      3'd0: b = 2'd3;
      3'd1: b = 2'd3;
      3'd2: b = 2'd0;
      3'd3: b = 2'd2;
      3'd4: b = 2'd3;
      3'd5: b = 2'd3;
      3'd6: b = 2'd1;
      3'd7: b = 2'd2;
      default: b = 2'd3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/delayed_write_bank_mapper_core.sv =====
// top level of the delayed write bank mapper
`default_nettype none

// Each bus access is one transfer on in_item, taken when start is high and busy
// is low. The result appears on out_item for exactly one cycle with out_strobe
// high, after the update and read states; busy stays high through the strobe,
// so the next access is taken only when the last one is done. This order comes
// from the single ram port, which first takes the delayed write and then the
// read of the mapped byte, whose data is registered before it is shown.
// The receiver cannot stall the result; it must take it in the strobe cycle.
module delayed_write_bank_mapper_core
  import dwbm_pkg::*;
#(
  parameter int BANK_BYTES = BANK_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dwbm_in_t in_item,
  output logic          out_strobe,
  output dwbm_out_t     out_item
);

  dwbm_cmd_t cmd;

  dwbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  dwbm_dp #(
    .BANK_BYTES (BANK_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("no result three cycles after a transfer was taken");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (busy && !cmd.update && !cmd.fetch))
    else $error("result shown while work still in progress");

  a_idle_cfg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> ($stable(out_item.rom_powered) && $stable(out_item.write_enabled)
      && $stable(out_item.lower_bank) && $stable(out_item.upper_bank)))
    else $error("bank configuration changed while idle");

endmodule

`default_nettype wire

// ===== hdl/dwbm_ctrl.sv =====
// sequencer for the mapper: take, update, memory read, present
`default_nettype none

module dwbm_ctrl
  import dwbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output dwbm_cmd_t      cmd,
  output logic           out_strobe
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_UPD;
      end
      ST_UPD:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.update  = (state_r == ST_UPD);
  assign cmd.fetch   = (state_r == ST_RD);
  assign out_strobe  = (state_r == ST_OUT);

endmodule

`default_nettype wire

// ===== hdl/dwbm_dp.sv =====
// mapper datapath: bank state, delayed write logic, ram and boot rom
`default_nettype none

module dwbm_dp
  import dwbm_pkg::*;
#(
  parameter int BANK_BYTES = BANK_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dwbm_cmd_t cmd,
  input  wire dwbm_in_t  in_item,
  output dwbm_out_t      out_item
);

  localparam int OFF_W     = $clog2(BANK_BYTES);
  localparam int RAM_DEPTH = 3 * BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  // compare-subtract steps that bring an 11-bit offset below BANK_BYTES
  localparam int MOD_STEPS = $clog2((2047 / BANK_BYTES) + 1);

  localparam logic [OFF_W-1:0] VEC_A = OFF_W'(12'h7FC % BANK_BYTES);
  localparam logic [OFF_W-1:0] VEC_B = OFF_W'(12'h7FD % BANK_BYTES);
  localparam logic [OFF_W-1:0] VEC_C = OFF_W'(12'h7FE % BANK_BYTES);
  localparam logic [OFF_W-1:0] VEC_D = OFF_W'(12'h7FF % BANK_BYTES);

  localparam logic [RAM_AW-1:0] BASE_1 = RAM_AW'(BANK_BYTES);
  localparam logic [RAM_AW-1:0] BASE_2 = RAM_AW'(2 * BANK_BYTES);

  // captured transfer
  logic        cmd_r;
  logic [11:0] addr_r;
  logic [31:0] count_r;

  // mapper state; due_r holds the arming count plus the write gap
  logic [7:0]  hold_r, hold_nxt;
  logic [31:0] due_r, due_nxt;
  logic        armed_r, armed_nxt;
  logic        wen_r, wen_nxt;
  logic        pwr_r, pwr_nxt;
  logic [2:0]  map_r, map_nxt;

  logic        armed_live;
  logic        ram_we;
  logic [1:0]  bank;
  logic [11:0] red;
  logic [OFF_W-1:0]  off;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]  rom_byte;

  logic [7:0]  ram_mem [RAM_DEPTH];
  logic [7:0]  ram_q_r;
  logic [7:0]  rom_q_r;
  logic        rom_sel_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_item.command;
      addr_r  <= in_item.address;
      count_r <= in_item.access_count;
    end
  end

  assign bank = addr_r[11] ? map_upper(map_r) : map_lower(map_r);

  always_comb begin
    red = {1'b0, addr_r[10:0]};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (red >= 12'(BANK_BYTES << k)) red = red - 12'(BANK_BYTES << k);
    end
  end

  assign off = red[OFF_W-1:0];

  always_comb begin
    case (bank)
      2'd0:    ram_addr = RAM_AW'(off);
      2'd1:    ram_addr = BASE_1 + RAM_AW'(off);
      2'd2:    ram_addr = BASE_2 + RAM_AW'(off);
      default: ram_addr = RAM_AW'(off);
    endcase
  end

  always_comb begin
    if (off == VEC_A || off == VEC_C) begin
      rom_byte = VEC_LO;
    end else if (off == VEC_B || off == VEC_D) begin
      rom_byte = VEC_HI;
    end else begin
      rom_byte = boot_byte(12'(off));
    end
  end

  always_comb begin
    armed_live = armed_r && !(count_r > due_r);
    hold_nxt   = hold_r;
    due_nxt    = due_r;
    armed_nxt  = armed_r;
    wen_nxt    = wen_r;
    pwr_nxt    = pwr_r;
    map_nxt    = map_r;
    ram_we     = 1'b0;
    if (cmd.update) begin
      armed_nxt = armed_live;
      // latch page; while a write is pending with writes on it cannot re-arm
      if (addr_r[11:8] == '0 && (!wen_r || !armed_live)) begin
        hold_nxt  = addr_r[7:0];
        due_nxt   = count_r + DUE_GAP;
        armed_nxt = 1'b1;
      end else if (addr_r == ADDR_CFG) begin
        armed_nxt = 1'b0;
        pwr_nxt   = !hold_r[0];
        wen_nxt   = hold_r[1];
        map_nxt   = hold_r[4:2];
      end else if (wen_r && armed_live && count_r == due_r) begin
        ram_we    = (bank != BANK_ROM);
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      due_r   <= DUE_GAP;
      armed_r <= 1'b0;
      wen_r   <= 1'b0;
      pwr_r   <= 1'b1;
      map_r   <= '0;
    end else begin
      hold_r  <= hold_nxt;
      due_r   <= due_nxt;
      armed_r <= armed_nxt;
      wen_r   <= wen_nxt;
      pwr_r   <= pwr_nxt;
      map_r   <= map_nxt;
    end
  end

  // single port ram: delayed write in the update step, read in the fetch step
  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_addr] <= hold_r;
    if (cmd.fetch) ram_q_r <= ram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rom_q_r   <= rom_byte;
      rom_sel_r <= (bank == BANK_ROM);
    end
  end

  assign out_item.read_data     = cmd_r ? 8'h00 : (rom_sel_r ? rom_q_r : ram_q_r);
  assign out_item.rom_powered   = pwr_r;
  assign out_item.write_enabled = wen_r;
  assign out_item.lower_bank    = map_lower(map_r);
  assign out_item.upper_bank    = map_upper(map_r);

endmodule

`default_nettype wire
